// ----- rtl/oal_pkg.sv -----
package oal_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int GROUP_SIZE = 8;
   localparam int GRP_W      = $clog2(GROUP_SIZE);
   localparam int NGROUPS    = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   typedef enum logic [2:0] {
      CMD_INSERT = 3'd0,
      CMD_DELETE = 3'd1,
      CMD_SET    = 3'd2,
      CMD_GET    = 3'd3,
      CMD_LOCATE = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_BADPOS   = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_GROUP,
      S_FINAL
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_SET
   } cell_mode_type;

   // Broadcast to every cell in the row.
   typedef struct packed {
      cell_mode_type                mode;
      logic [IDX_W-1:0]             slot;
      logic signed [DATA_WIDTH-1:0] value;
      logic [CNT_W-1:0]             count;
      logic                         probe;
   } cell_ctl_type;

   typedef struct packed {
      logic                         any;
      logic [GRP_W-1:0]             first;
      logic signed [DATA_WIDTH-1:0] data;
   } grp_type;

endpackage

// ----- rtl/ordered_array_list_engine.sv -----
// Ordered list engine: a row of cells, one list entry per cell.
// A command passes decode and shift, group reduce and final select into the
// output register before rsp_valid rises.
// A new command is accepted only once the previous one has been loaded into
// the output register; a stalled rsp word holds off the next command.
// Reset clears the list length and the handshake state; cell contents are
// not reset and are only read below the list length.
module ordered_array_list_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [2:0]                            req_cmd,
   input  logic [oal_pkg::CNT_W-1:0]             req_position,
   input  logic signed [oal_pkg::DATA_WIDTH-1:0] req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic signed [oal_pkg::DATA_WIDTH-1:0] rsp_read_value,
   output logic [oal_pkg::CNT_W-1:0]             rsp_found_position,
   output logic [oal_pkg::CNT_W-1:0]             rsp_list_length,
   output logic                                  rsp_is_empty
);
   import oal_pkg::*;

   state_type                    state_ff, state_in;
   logic [2:0]                   cmd_ff;
   logic [CNT_W-1:0]             pos_ff;
   logic signed [DATA_WIDTH-1:0] value_ff;
   logic [CNT_W-1:0]             count_ff, count_in;
   status_type                   status_ff, status_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   rsp_status_ff, rsp_status_in;
   logic signed [DATA_WIDTH-1:0] rsp_read_ff, rsp_read_in;
   logic [CNT_W-1:0]             rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0]             rsp_length_ff;
   logic                         rsp_empty_ff;

   logic                         accept;
   logic                         exec_en;
   logic                         load_rsp;
   logic                         out_free;

   logic                         pos_ok_rd;
   logic                         pos_ok_ins;
   logic                         full;
   cell_ctl_type                 ctl;

   logic signed [DATA_WIDTH-1:0] cell_data [CAPACITY];
   logic signed [DATA_WIDTH-1:0] cell_pick [CAPACITY];
   logic [CAPACITY-1:0]          cell_match;
   grp_type                      grp [NGROUPS];

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) begin
            state_in = S_EXEC;
         end
         S_EXEC:  state_in = S_GROUP;
         S_GROUP: state_in = S_FINAL;
         S_FINAL: if (out_free) begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall = 1'b1;
      exec_en   = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         S_IDLE:  req_stall = 1'b0;
         S_EXEC:  exec_en   = 1'b1;
         S_GROUP: ;
         S_FINAL: load_rsp  = out_free;
         default: req_stall = 1'b1;
      endcase
   end

   assign pos_ok_rd  = (pos_ff != '0) && (pos_ff <= count_ff);
   assign pos_ok_ins = (pos_ff != '0) && ({1'b0, pos_ff} <= ({1'b0, count_ff} + 1'b1));
   assign full       = (count_ff == CNT_W'(CAPACITY));

   // Decode: status, length update and the command broadcast to the cells.
   always_comb begin
      status_in   = STAT_OK;
      count_in    = count_ff;
      ctl.mode    = CELL_HOLD;
      ctl.slot    = IDX_W'(pos_ff - 1'b1);
      ctl.value   = value_ff;
      ctl.count   = count_ff;
      ctl.probe   = exec_en;
      unique case (cmd_ff)
         CMD_INSERT: begin
            if (!pos_ok_ins) begin
               status_in = STAT_BADPOS;
            end else if (full) begin
               status_in = STAT_FULL;
            end else begin
               ctl.mode = CELL_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_DELETE: begin
            if (!pos_ok_rd) begin
               status_in = STAT_BADPOS;
            end else begin
               ctl.mode = CELL_DELETE;
               count_in = count_ff - 1'b1;
            end
         end
         CMD_SET: begin
            if (!pos_ok_rd) begin
               status_in = STAT_BADPOS;
            end else begin
               ctl.mode = CELL_SET;
            end
         end
         CMD_GET: begin
            if (!pos_ok_rd) begin
               status_in = STAT_BADPOS;
            end
         end
         CMD_CLEAR: count_in = '0;
         default:   status_in = STAT_OK;
      endcase
      if (!exec_en) begin
         ctl.mode = CELL_HOLD;
         count_in = count_ff;
      end
   end

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic signed [DATA_WIDTH-1:0] left_word;
         logic signed [DATA_WIDTH-1:0] right_word;
         if (i == 0) begin : g_first
            assign left_word = value_ff;
         end else begin : g_left
            assign left_word = cell_data[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign right_word = cell_data[i];
         end else begin : g_right
            assign right_word = cell_data[i+1];
         end
         oal_cell u_cell (
            .clock      (clock),
            .index      (IDX_W'(i)),
            .ctl        (ctl),
            .left_data  (left_word),
            .right_data (right_word),
            .data_ff    (cell_data[i]),
            .match_ff   (cell_match[i]),
            .pick_ff    (cell_pick[i])
         );
      end
   endgenerate

   oal_reduce u_reduce (
      .clock  (clock),
      .match  (cell_match),
      .pick   (cell_pick),
      .grp_ff (grp)
   );

   // Final select across the groups: lowest matching group wins.
   always_comb begin
      logic                         hit;
      logic [CNT_W-1:0]             fpos;
      logic signed [DATA_WIDTH-1:0] rd;
      hit  = 1'b0;
      fpos = '0;
      rd   = '0;
      for (int g = NGROUPS - 1; g >= 0; g--) begin
         rd = rd | grp[g].data;
         if (grp[g].any) begin
            hit  = 1'b1;
            fpos = CNT_W'(g * GROUP_SIZE) + CNT_W'(grp[g].first) + CNT_W'(1);
         end
      end
      rsp_status_in = status_ff;
      rsp_read_in   = '0;
      rsp_found_in  = '0;
      if (cmd_ff == CMD_LOCATE) begin
         rsp_status_in = hit ? STAT_OK : STAT_NOTFOUND;
         rsp_found_in  = hit ? fpos : '0;
      end else if (cmd_ff == CMD_GET && status_ff == STAT_OK) begin
         rsp_read_in = rd;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
      if (exec_en) begin
         status_ff <= status_in;
      end
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_read_ff   <= rsp_read_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_length_ff <= count_ff;
         rsp_empty_ff  <= (count_ff == '0);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_value     = rsp_read_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_list_length    = rsp_length_ff;
   assign rsp_is_empty       = rsp_empty_ff;

endmodule

// ----- rtl/oal_cell.sv -----
module oal_cell (
   input  logic                                 clock,
   input  logic [oal_pkg::IDX_W-1:0]            index,
   input  oal_pkg::cell_ctl_type                ctl,
   input  logic signed [oal_pkg::DATA_WIDTH-1:0] left_data,
   input  logic signed [oal_pkg::DATA_WIDTH-1:0] right_data,
   output logic signed [oal_pkg::DATA_WIDTH-1:0] data_ff,
   output logic                                 match_ff,
   output logic signed [oal_pkg::DATA_WIDTH-1:0] pick_ff
);
   import oal_pkg::*;

   logic signed [DATA_WIDTH-1:0] data_in;
   logic                         match_in;
   logic signed [DATA_WIDTH-1:0] pick_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctl.mode)
         CELL_INSERT: begin
            if (index == ctl.slot) begin
               data_in = ctl.value;
            end else if (index > ctl.slot) begin
               data_in = left_data;
            end
         end
         CELL_DELETE: begin
            if (index >= ctl.slot) begin
               data_in = right_data;
            end
         end
         CELL_SET: begin
            if (index == ctl.slot) begin
               data_in = ctl.value;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   // Only occupied cells may report a match.
   assign match_in = (data_ff == ctl.value) && (CNT_W'(index) < ctl.count);
   assign pick_in  = (index == ctl.slot) ? data_ff : '0;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (ctl.probe) begin
         match_ff <= match_in;
         pick_ff  <= pick_in;
      end
   end

endmodule

// ----- rtl/oal_reduce.sv -----
module oal_reduce (
   input  logic                                  clock,
   input  logic [oal_pkg::CAPACITY-1:0]          match,
   input  logic signed [oal_pkg::DATA_WIDTH-1:0] pick [oal_pkg::CAPACITY],
   output oal_pkg::grp_type                      grp_ff [oal_pkg::NGROUPS]
);
   import oal_pkg::*;

   logic [NGROUPS*GROUP_SIZE-1:0] match_pad;
   logic signed [DATA_WIDTH-1:0]  pick_pad [NGROUPS*GROUP_SIZE];
   grp_type                       grp_in [NGROUPS];

   always_comb begin
      match_pad = '0;
      for (int k = 0; k < NGROUPS * GROUP_SIZE; k++) begin
         pick_pad[k] = '0;
      end
      for (int k = 0; k < CAPACITY; k++) begin
         match_pad[k] = match[k];
         pick_pad[k]  = pick[k];
      end
   end

   // Scanning downward leaves the lowest matching slot of each group.
   always_comb begin
      for (int g = 0; g < NGROUPS; g++) begin
         grp_in[g].any   = 1'b0;
         grp_in[g].first = '0;
         grp_in[g].data  = '0;
         for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
            grp_in[g].data = grp_in[g].data | pick_pad[g*GROUP_SIZE + j];
            if (match_pad[g*GROUP_SIZE + j]) begin
               grp_in[g].any   = 1'b1;
               grp_in[g].first = GRP_W'(j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

endmodule
